[src/bdf_pkg.sv]
// shared constants, types and reciprocal tables of the box downsampler
package bdf_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_BPP     = 4;
  localparam int MAX_FACTOR  = 16;
  localparam int MAX_HEIGHT  = 4096;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_BPP;

  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int COMP_W  = $clog2(MAX_BPP);
  localparam int PHASE_W = $clog2(MAX_FACTOR);

  localparam int PIXEL_W    = 8;
  localparam int FACTOR_W   = 5;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int BPP_W      = 3;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [FACTOR_W-1:0] FACTOR_RST = FACTOR_W'(2);
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(1024);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(768);
  localparam logic [BPP_W-1:0]    BPP_RST    = BPP_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FACTOR = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_BPP    = 2'd3
  } cfg_reg_t;

  // ceil(2^16 / d), exact quotient for the operand ranges used here
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 17;

  // divisor f, indexed by f - 1
  localparam logic [RECIP_W-1:0] RECIP_F [MAX_FACTOR] = '{
    17'd65536, 17'd32768, 17'd21846, 17'd16384,
    17'd13108, 17'd10923, 17'd9363,  17'd8192,
    17'd7282,  17'd6554,  17'd5958,  17'd5462,
    17'd5042,  17'd4682,  17'd4370,  17'd4096
  };

  // divisor f * f, indexed by f - 1
  localparam logic [RECIP_W-1:0] RECIP_FF [MAX_FACTOR] = '{
    17'd65536, 17'd16384, 17'd7282,  17'd4096,
    17'd2622,  17'd1821,  17'd1338,  17'd1024,
    17'd810,   17'd656,   17'd542,   17'd456,
    17'd388,   17'd335,   17'd292,   17'd256
  };

endpackage

[src/bdf_in_if.sv]
// input channel: one component byte per transaction
interface bdf_in_if;
  logic                        valid;
  logic                        ready;
  logic [bdf_pkg::PIXEL_W-1:0] pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink (input valid, input pixel_byte, output ready);
endinterface

[src/bdf_out_if.sv]
// output channel: one downscaled component byte per transaction
interface bdf_out_if;
  logic                        valid;
  logic                        ready;
  logic [bdf_pkg::PIXEL_W-1:0] out_byte;
  logic                        last_of_image;

  modport source (output valid, output out_byte, output last_of_image, input ready);
  modport sink (input valid, input out_byte, input last_of_image, output ready);
endinterface

[src/bdf_ram.sv]
// generic single-port-write, registered-read RAM
module bdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/box_downsample_by_factor_unit.sv]
// box downsampler top level: counters, line store pipeline and output register
//
// Usage: component bytes of an unpadded raster image enter on pixels, one per
// transaction, row-major. Each F-by-F block of pixels yields one byte per
// component on results, the sum of every pixel divided by F*F on its own;
// last_of_image marks the final byte of the image. Partial right and bottom
// blocks produce nothing and counters wrap for the next image.
// Configuration (factor, width, height, bytes per pixel) is written through
// cfg_write/cfg_index/cfg_data; the user must do so only while no transaction
// is in flight, as the block itself does not enforce it.
// Throughput: one byte per clock unless the output blocks; the per-column
// sums live in one line store RAM, read in stage 2 and written back in
// stage 3, with forwarding between back-to-back accesses to the same column.
// Reset: synchronous, clears the counters and the pipeline and restores the
// default configuration; the line store is not cleared, its entries are
// always written by the first pixel of a block before they are read.
// Stall: a finished byte waits in the output register; input keeps flowing
// until a second byte must be delivered while that register is still full.
module box_downsample_by_factor_unit (
  input  logic                           clk,
  input  logic                           rst,
  bdf_in_if.sink                         pixels,
  bdf_out_if.source                      results,
  input  logic                           cfg_write,
  input  logic [bdf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W    = bdf_pkg::COL_W;
  localparam int ROW_W    = bdf_pkg::ROW_W;
  localparam int COMP_W   = bdf_pkg::COMP_W;
  localparam int PHASE_W  = bdf_pkg::PHASE_W;
  localparam int ADDR_W   = bdf_pkg::ADDR_W;
  localparam int PIXEL_W  = bdf_pkg::PIXEL_W;
  localparam int FACTOR_W = bdf_pkg::FACTOR_W;
  localparam int WIDTH_W  = bdf_pkg::WIDTH_W;
  localparam int HEIGHT_W = bdf_pkg::HEIGHT_W;
  localparam int BPP_W    = bdf_pkg::BPP_W;
  localparam int RECIP_W  = bdf_pkg::RECIP_W;
  localparam int RSH      = bdf_pkg::RECIP_SHIFT;

  // configuration registers
  logic [FACTOR_W-1:0] factor;
  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [BPP_W-1:0]    bytes_per_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor          <= bdf_pkg::FACTOR_RST;
      image_width     <= bdf_pkg::WIDTH_RST;
      image_height    <= bdf_pkg::HEIGHT_RST;
      bytes_per_pixel <= bdf_pkg::BPP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bdf_pkg::CFG_FACTOR: factor          <= cfg_data[FACTOR_W-1:0];
        bdf_pkg::CFG_WIDTH:  image_width     <= cfg_data[WIDTH_W-1:0];
        bdf_pkg::CFG_HEIGHT: image_height    <= cfg_data[HEIGHT_W-1:0];
        bdf_pkg::CFG_BPP:    bytes_per_pixel <= cfg_data[BPP_W-1:0];
      endcase
    end
  end

  // clamped configuration
  logic [FACTOR_W-1:0] f_c;
  logic [WIDTH_W-1:0]  w_c;
  logic [HEIGHT_W-1:0] h_c;
  logic [BPP_W-1:0]    b_c;
  logic [PHASE_W-1:0]  f_sel;
  logic [FACTOR_W-1:0] f_m1;
  logic [RECIP_W-1:0]  rf;
  logic [RECIP_W-1:0]  rff;

  always_comb begin
    if (factor == '0) begin
      f_c = FACTOR_W'(1);
    end else if (factor > FACTOR_W'(bdf_pkg::MAX_FACTOR)) begin
      f_c = FACTOR_W'(bdf_pkg::MAX_FACTOR);
    end else begin
      f_c = factor;
    end
    if (image_width == '0) begin
      w_c = WIDTH_W'(1);
    end else if (image_width > WIDTH_W'(bdf_pkg::MAX_WIDTH)) begin
      w_c = WIDTH_W'(bdf_pkg::MAX_WIDTH);
    end else begin
      w_c = image_width;
    end
    if (image_height == '0) begin
      h_c = HEIGHT_W'(1);
    end else if (image_height > HEIGHT_W'(bdf_pkg::MAX_HEIGHT)) begin
      h_c = HEIGHT_W'(bdf_pkg::MAX_HEIGHT);
    end else begin
      h_c = image_height;
    end
    if (bytes_per_pixel == '0) begin
      b_c = BPP_W'(1);
    end else if (bytes_per_pixel > BPP_W'(bdf_pkg::MAX_BPP)) begin
      b_c = BPP_W'(bdf_pkg::MAX_BPP);
    end else begin
      b_c = bytes_per_pixel;
    end
  end

  assign f_m1  = f_c - FACTOR_W'(1);
  assign f_sel = f_m1[PHASE_W-1:0];
  assign rf    = bdf_pkg::RECIP_F[f_sel];
  assign rff   = bdf_pkg::RECIP_FF[f_sel];

  // used image area, width / f * f and height / f * f
  logic [WIDTH_W+RECIP_W-1:0]  prod_w;
  logic [HEIGHT_W+RECIP_W-1:0] prod_h;
  logic [WIDTH_W-1:0]          blocks_w;
  logic [HEIGHT_W-1:0]         blocks_h;
  logic [WIDTH_W-1:0]          used_w;
  logic [HEIGHT_W-1:0]         used_h;

  assign prod_w = w_c * rf;
  assign prod_h = h_c * rf;

  always_ff @(posedge clk) begin
    blocks_w <= prod_w[RSH +: WIDTH_W];
    blocks_h <= prod_h[RSH +: HEIGHT_W];
    used_w   <= WIDTH_W'(blocks_w * f_c);
    used_h   <= HEIGHT_W'(blocks_h * f_c);
  end

  // handshake
  logic advance;
  logic accept;
  logic out_valid;
  logic s3_valid;
  logic s3_emit;

  assign advance      = !(out_valid && !results.ready) || !(s3_valid && s3_emit);
  assign pixels.ready = advance;
  assign accept       = pixels.valid && advance;

  // raster position counters
  logic [COL_W-1:0]   col, col_next;
  logic [ROW_W-1:0]   row, row_next;
  logic [COMP_W-1:0]  comp, comp_next;
  logic [PHASE_W-1:0] cph, cph_next;
  logic [PHASE_W-1:0] rph, rph_next;
  logic [COMP_W-1:0]  comp_inc;
  logic [COL_W:0]     col_inc;
  logic [ROW_W:0]     row_inc;
  logic [PHASE_W:0]   cph_inc;
  logic [PHASE_W:0]   rph_inc;

  assign comp_inc = comp + COMP_W'(1);
  assign col_inc  = {1'b0, col} + (COL_W+1)'(1);
  assign row_inc  = {1'b0, row} + (ROW_W+1)'(1);
  assign cph_inc  = {1'b0, cph} + (PHASE_W+1)'(1);
  assign rph_inc  = {1'b0, rph} + (PHASE_W+1)'(1);

  always_comb begin
    comp_next = comp;
    col_next  = col;
    row_next  = row;
    cph_next  = cph;
    rph_next  = rph;
    if (accept) begin
      comp_next = comp_inc;
      if (BPP_W'(comp_inc) >= b_c || comp_inc == '0) begin
        comp_next = '0;
        col_next  = col_inc[COL_W-1:0];
        cph_next  = (cph_inc >= f_c) ? '0 : cph_inc[PHASE_W-1:0];
        if (col_inc >= w_c) begin
          col_next = '0;
          cph_next = '0;
          row_next = row_inc[ROW_W-1:0];
          rph_next = (rph_inc >= f_c) ? '0 : rph_inc[PHASE_W-1:0];
          if (row_inc >= h_c) begin
            row_next = '0;
            rph_next = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      comp <= '0;
      cph  <= '0;
      rph  <= '0;
    end else begin
      col  <= col_next;
      row  <= row_next;
      comp <= comp_next;
      cph  <= cph_next;
      rph  <= rph_next;
    end
  end

  // stage 1: reciprocal multiplies
  logic                s1_valid;
  logic [PIXEL_W-1:0]  s1_pixel;
  logic [COL_W-1:0]    s1_col;
  logic [ROW_W-1:0]    s1_row;
  logic [COMP_W-1:0]   s1_comp;
  logic [PHASE_W-1:0]  s1_cph;
  logic [PHASE_W-1:0]  s1_rph;
  logic [COL_W+RECIP_W-1:0]   prod_c;
  logic [PIXEL_W+RECIP_W-1:0] prod_p;

  assign prod_c = s1_col * rf;
  assign prod_p = s1_pixel * rff;

  // stage 2: address, area checks and line store read
  logic                s2_valid;
  logic [COL_W-1:0]    s2_qc;
  logic [PIXEL_W-1:0]  s2_part;
  logic [COL_W-1:0]    s2_col;
  logic [ROW_W-1:0]    s2_row;
  logic [COMP_W-1:0]   s2_comp;
  logic [PHASE_W-1:0]  s2_cph;
  logic [PHASE_W-1:0]  s2_rph;
  logic [COL_W+BPP_W-1:0] s2_base;
  logic [ADDR_W-1:0]   s2_idx;
  logic                s2_in;
  logic                s2_first;
  logic                s2_emit;
  logic                s2_last;

  assign s2_base  = s2_qc * b_c;
  assign s2_idx   = ADDR_W'(s2_base + (COL_W+BPP_W)'(s2_comp));
  assign s2_in    = {1'b0, s2_col} < used_w && {1'b0, s2_row} < used_h
                    && BPP_W'(s2_comp) < b_c;
  assign s2_first = s2_rph == '0 && s2_cph == '0;
  assign s2_emit  = FACTOR_W'(s2_rph) == f_m1 && FACTOR_W'(s2_cph) == f_m1;
  assign s2_last  = {1'b0, s2_row} == used_h - HEIGHT_W'(1)
                    && {1'b0, s2_col} == used_w - WIDTH_W'(1)
                    && BPP_W'(s2_comp) == b_c - BPP_W'(1);

  // stage 3: accumulate and write back
  logic                s3_we;
  logic                s3_first;
  logic                s3_last;
  logic [PIXEL_W-1:0]  s3_part;
  logic [ADDR_W-1:0]   s3_idx;
  logic                s3_fwd;
  logic [PIXEL_W-1:0]  s3_fwd_data;
  logic [PIXEL_W-1:0]  ram_rdata;
  logic [PIXEL_W-1:0]  s3_prev;
  logic [PIXEL_W-1:0]  sum;

  assign s3_prev = s3_fwd ? s3_fwd_data : ram_rdata;
  assign sum     = s3_first ? s3_part : s3_prev + s3_part;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s3_fwd   <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s3_fwd   <= s2_valid && s3_valid && s3_we && s3_idx == s2_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_pixel    <= pixels.pixel_byte;
      s1_col      <= col;
      s1_row      <= row;
      s1_comp     <= comp;
      s1_cph      <= cph;
      s1_rph      <= rph;
      s2_qc       <= prod_c[RSH +: COL_W];
      s2_part     <= prod_p[RSH +: PIXEL_W];
      s2_col      <= s1_col;
      s2_row      <= s1_row;
      s2_comp     <= s1_comp;
      s2_cph      <= s1_cph;
      s2_rph      <= s1_rph;
      s3_we       <= s2_in;
      s3_first    <= s2_first;
      s3_emit     <= s2_in && s2_emit;
      s3_last     <= s2_last;
      s3_part     <= s2_part;
      s3_idx      <= s2_idx;
      s3_fwd_data <= sum;
    end
  end

  bdf_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (bdf_pkg::STORE_DEPTH)
  ) u_column_sums (
    .clk   (clk),
    .we    (advance && s3_valid && s3_we),
    .waddr (s3_idx),
    .wdata (sum),
    .re    (advance && s2_valid),
    .raddr (s2_idx),
    .rdata (ram_rdata)
  );

  // output register
  logic [PIXEL_W-1:0] out_byte;
  logic               out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s3_valid && s3_emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s3_valid && s3_emit) begin
      out_byte <= sum;
      out_last <= s3_last;
    end
  end

  assign results.valid         = out_valid;
  assign results.out_byte      = out_byte;
  assign results.last_of_image = out_last;

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !pixels.ready |-> out_valid && !results.ready && s3_valid && s3_emit)
    else $error("input stalled without a blocked result");

  a_emit_in_area: assert property (@(posedge clk) disable iff (rst)
    s3_valid && s3_emit |-> s3_we)
    else $error("result from a pixel outside the used area");

  a_fwd_has_item: assert property (@(posedge clk) disable iff (rst)
    s3_fwd |-> s3_valid)
    else $error("forwarding set without an item in the last stage");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !s1_valid && !s2_valid && !s3_valid && !out_valid
            && col == '0 && row == '0 && comp == '0)
    else $error("pipeline or counters not cleared by reset");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// testbench of the box downsampler: directed and random images checked by a behavioral predictor
module testbench;

  localparam int PIXEL_W     = bdf_pkg::PIXEL_W;
  localparam int CFG_DATA_W  = bdf_pkg::CFG_DATA_W;
  localparam int FACTOR_W    = bdf_pkg::FACTOR_W;
  localparam int WIDTH_W     = bdf_pkg::WIDTH_W;
  localparam int HEIGHT_W    = bdf_pkg::HEIGHT_W;
  localparam int BPP_W       = bdf_pkg::BPP_W;
  localparam int STORE_DEPTH = bdf_pkg::STORE_DEPTH;
  localparam int MAX_FACTOR  = bdf_pkg::MAX_FACTOR;
  localparam int MAX_WIDTH   = bdf_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT  = bdf_pkg::MAX_HEIGHT;
  localparam int MAX_BPP     = bdf_pkg::MAX_BPP;

  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BYTES  = 500;
  localparam int DIRECTED_ROWS = 33;

  typedef struct packed {
    logic [PIXEL_W-1:0] out_byte;
    logic               last_of_image;
  } down_byte_t;

  typedef enum logic [1:0] {ROW_CONFIG, ROW_PIXEL, ROW_PIXEL_EXPECT} stim_kind_t;
  typedef enum logic [1:0] {DRAIN_FREE, DRAIN_RANDOM, DRAIN_SLOW} drain_mode_t;

  typedef struct {
    stim_kind_t         kind;
    bdf_pkg::cfg_reg_t  sel;
    int unsigned        value;
    logic [PIXEL_W-1:0] pixel;
    down_byte_t         want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  bdf_pkg::cfg_reg_t     cfg_index = bdf_pkg::CFG_FACTOR;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bdf_in_if  pixels_if ();
  bdf_out_if results_if ();

  box_downsample_by_factor_unit dut (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pixels_if),
    .results   (results_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // shadow registers and state of the downsampler
  logic [FACTOR_W-1:0] cur_factor = bdf_pkg::FACTOR_RST;
  logic [WIDTH_W-1:0]  cur_width  = bdf_pkg::WIDTH_RST;
  logic [HEIGHT_W-1:0] cur_height = bdf_pkg::HEIGHT_RST;
  logic [BPP_W-1:0]    cur_bpp    = bdf_pkg::BPP_RST;
  logic [PIXEL_W-1:0]  block_sums [STORE_DEPTH];
  int unsigned col = 0, comp = 0, row = 0, row_ph = 0, col_ph = 0;

  down_byte_t  bytes_due [$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned ready_left = 0;
  drain_mode_t drain_mode = DRAIN_FREE;

  // reset defaults first, then a mid-image resize, then extremes and truncation
  stim_row_t directed [DIRECTED_ROWS] = '{
    '{ROW_PIXEL, bdf_pkg::CFG_FACTOR, 0, 8'd200, '0},
    '{ROW_PIXEL, bdf_pkg::CFG_FACTOR, 0, 8'd40, '0},
    '{ROW_PIXEL, bdf_pkg::CFG_FACTOR, 0, 8'd255, '0},
    '{ROW_PIXEL, bdf_pkg::CFG_FACTOR, 0, 8'd17, '0},
    '{ROW_PIXEL, bdf_pkg::CFG_FACTOR, 0, 8'd99, '0},
    '{ROW_PIXEL, bdf_pkg::CFG_FACTOR, 0, 8'd0, '0},
    '{ROW_CONFIG, bdf_pkg::CFG_WIDTH, 2, 8'd0, '0},
    '{ROW_CONFIG, bdf_pkg::CFG_HEIGHT, 2, 8'd0, '0},
    '{ROW_PIXEL, bdf_pkg::CFG_FACTOR, 0, 8'd255, '0},
    '{ROW_PIXEL, bdf_pkg::CFG_FACTOR, 0, 8'd255, '0},
    '{ROW_PIXEL, bdf_pkg::CFG_FACTOR, 0, 8'd255, '0},
    '{ROW_PIXEL, bdf_pkg::CFG_FACTOR, 0, 8'd128, '0},
    '{ROW_PIXEL, bdf_pkg::CFG_FACTOR, 0, 8'd7, '0},
    '{ROW_PIXEL, bdf_pkg::CFG_FACTOR, 0, 8'd255, '0},
    '{ROW_PIXEL, bdf_pkg::CFG_FACTOR, 0, 8'd64, '0},
    '{ROW_PIXEL, bdf_pkg::CFG_FACTOR, 0, 8'd3, '0},
    '{ROW_PIXEL, bdf_pkg::CFG_FACTOR, 0, 8'd251, '0},
    '{ROW_CONFIG, bdf_pkg::CFG_FACTOR, 1, 8'd0, '0},
    '{ROW_CONFIG, bdf_pkg::CFG_BPP, 4, 8'd0, '0},
    '{ROW_CONFIG, bdf_pkg::CFG_WIDTH, 1, 8'd0, '0},
    '{ROW_CONFIG, bdf_pkg::CFG_HEIGHT, 1, 8'd0, '0},
    '{ROW_PIXEL_EXPECT, bdf_pkg::CFG_FACTOR, 0, 8'h00, '{8'h00, 1'b0}},
    '{ROW_PIXEL_EXPECT, bdf_pkg::CFG_FACTOR, 0, 8'hFF, '{8'hFF, 1'b0}},
    '{ROW_PIXEL_EXPECT, bdf_pkg::CFG_FACTOR, 0, 8'hAA, '{8'hAA, 1'b0}},
    '{ROW_PIXEL_EXPECT, bdf_pkg::CFG_FACTOR, 0, 8'h55, '{8'h55, 1'b1}},
    '{ROW_CONFIG, bdf_pkg::CFG_FACTOR, 2, 8'd0, '0},
    '{ROW_CONFIG, bdf_pkg::CFG_WIDTH, 2, 8'd0, '0},
    '{ROW_CONFIG, bdf_pkg::CFG_HEIGHT, 2, 8'd0, '0},
    '{ROW_CONFIG, bdf_pkg::CFG_BPP, 1, 8'd0, '0},
    '{ROW_PIXEL, bdf_pkg::CFG_FACTOR, 0, 8'd3, '0},
    '{ROW_PIXEL, bdf_pkg::CFG_FACTOR, 0, 8'd7, '0},
    '{ROW_PIXEL, bdf_pkg::CFG_FACTOR, 0, 8'd11, '0},
    '{ROW_PIXEL_EXPECT, bdf_pkg::CFG_FACTOR, 0, 8'd255, '{8'd66, 1'b1}}
  };

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit downsample_step(input logic [PIXEL_W-1:0] p, output down_byte_t res);
    int unsigned f, w, h, b, used_w, used_h, idx;
    logic [PIXEL_W-1:0] sum;
    bit emit;
    f = clamp_to(cur_factor, MAX_FACTOR);
    w = clamp_to(cur_width, MAX_WIDTH);
    h = clamp_to(cur_height, MAX_HEIGHT);
    b = clamp_to(cur_bpp, MAX_BPP);
    used_w = (w / f) * f;
    used_h = (h / f) * f;
    emit = 1'b0;
    res = '0;
    if (col < used_w && row < used_h && comp < b) begin
      idx = (col / f) * b + comp;
      if (row_ph == 0 && col_ph == 0) begin
        sum = PIXEL_W'(p / (f * f));
      end else begin
        sum = PIXEL_W'(block_sums[idx] + p / (f * f));
      end
      block_sums[idx] = sum;
      if (row_ph == f - 1 && col_ph == f - 1) begin
        emit = 1'b1;
        res.out_byte = sum;
        res.last_of_image = (row == used_h - 1 && col == used_w - 1 && comp == b - 1);
      end
    end
    comp = (comp + 1) % 4;
    if (comp >= b || comp == 0) begin
      comp = 0;
      col++;
      col_ph++;
      if (col_ph >= f) col_ph = 0;
      if (col >= w) begin
        col = 0;
        col_ph = 0;
        row++;
        row_ph++;
        if (row_ph >= f) row_ph = 0;
        if (row >= h) begin
          row = 0;
          row_ph = 0;
        end
      end
    end
    return emit;
  endfunction

  function automatic logic [PIXEL_W-1:0] random_component();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return PIXEL_W'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [PIXEL_W-1:0] p, input bit typed, input down_byte_t want);
    down_byte_t res;
    if (burst_left == 0) begin
      pixels_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 200) : $urandom_range(1, 24);
    end
    burst_left--;
    pixels_if.valid      <= 1'b1;
    pixels_if.pixel_byte <= p;
    @(posedge clk);
    while (!pixels_if.ready) @(posedge clk);
    if (downsample_step(p, res) || typed) bytes_due.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  task automatic send_image(input int unsigned count);
    repeat (count) send_byte(random_component(), 1'b0, '0);
  endtask

  task automatic wait_drained();
    pixels_if.valid <= 1'b0;
    while (bytes_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input bdf_pkg::cfg_reg_t sel, input int unsigned value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    case (sel)
      bdf_pkg::CFG_FACTOR: cur_factor = FACTOR_W'(value);
      bdf_pkg::CFG_WIDTH:  cur_width  = WIDTH_W'(value);
      bdf_pkg::CFG_HEIGHT: cur_height = HEIGHT_W'(value);
      bdf_pkg::CFG_BPP:    cur_bpp    = BPP_W'(value);
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_geometry(input int unsigned f_raw, w_raw, h_raw, b_raw);
    wait_drained();
    write_reg(bdf_pkg::CFG_FACTOR, f_raw);
    write_reg(bdf_pkg::CFG_WIDTH, w_raw);
    write_reg(bdf_pkg::CFG_HEIGHT, h_raw);
    write_reg(bdf_pkg::CFG_BPP, b_raw);
  endtask

  // output side stalls in windows of its own
  always @(negedge clk) begin
    if (ready_left == 0) begin
      drain_mode = drain_mode_t'($urandom_range(0, 2));
      ready_left = $urandom_range(8, 64);
    end
    ready_left--;
    case (drain_mode)
      DRAIN_FREE:   results_if.ready <= 1'b1;
      DRAIN_RANDOM: results_if.ready <= ($urandom_range(0, 3) != 0);
      default:      results_if.ready <= (ready_left % 4 == 0);
    endcase
  end

  always @(posedge clk) begin
    down_byte_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (bytes_due.size() == 0) begin
        $error("out_byte %0d: transaction with nothing pending", results_if.out_byte);
        mismatches++;
      end else begin
        want = bytes_due.pop_front();
        if (results_if.out_byte !== want.out_byte) begin
          $error("out_byte mismatch: expected %0d, actual %0d",
                 want.out_byte, results_if.out_byte);
          mismatches++;
        end
        if (results_if.last_of_image !== want.last_of_image) begin
          $error("last_of_image mismatch: expected %0d, actual %0d",
                 want.last_of_image, results_if.last_of_image);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned f, w, h, b, f_raw, w_raw, h_raw, b_raw;
    int unsigned random_bytes;
    random_bytes = 0;
    pixels_if.valid      = 1'b0;
    pixels_if.pixel_byte = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      case (directed[i].kind)
        ROW_CONFIG: begin
          wait_drained();
          write_reg(directed[i].sel, directed[i].value);
        end
        ROW_PIXEL:        send_byte(directed[i].pixel, 1'b0, '0);
        ROW_PIXEL_EXPECT: send_byte(directed[i].pixel, 1'b1, directed[i].want);
      endcase
    end

    for (int img = 0; random_bytes < RANDOM_BYTES; img++) begin
      if (img == 0 || $urandom_range(0, 11) == 0) begin
        f = MAX_FACTOR;
        w = $urandom_range(16, 18);
        h = 16;
        b = 1;
      end else begin
        f = $urandom_range(1, 4);
        b = (f <= 2) ? $urandom_range(1, 4) : $urandom_range(1, 2);
        w = f * $urandom_range(1, f == 1 ? 6 : 2) + $urandom_range(0, f - 1);
        h = f * $urandom_range(1, f == 1 ? 6 : 2) + $urandom_range(0, f - 1);
        if ($urandom_range(0, 7) == 0) w = $urandom_range(1, f);
        if ($urandom_range(0, 7) == 0) h = $urandom_range(1, f);
      end
      f_raw = f;
      w_raw = w;
      h_raw = h;
      b_raw = b;
      if (f == 1 && $urandom_range(0, 1)) f_raw = 0;
      if (f == MAX_FACTOR && $urandom_range(0, 1)) f_raw = $urandom_range(17, 31);
      if (w == 1 && $urandom_range(0, 1)) w_raw = 0;
      if (h == 1 && $urandom_range(0, 1)) h_raw = 0;
      if (b == 1 && $urandom_range(0, 1)) b_raw = 0;
      if (b == MAX_BPP && $urandom_range(0, 1)) b_raw = $urandom_range(5, 7);
      load_geometry(f_raw, w_raw, h_raw, b_raw);
      send_image(w * h * b);
      random_bytes += w * h * b;
    end

    wait_drained();
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
